>>> hw/rtl/npt_pkg.sv
// Package for the nearest previous taller finder.
// Field widths, default capacity and sequencer state type; no dependencies.
package npt_pkg;

  localparam int unsigned HEIGHT_W       = 32;
  localparam int unsigned NUM_W          = 11;
  localparam int unsigned MAX_TOWERS_DEF = 1024;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_PUSH
  } npt_state_e;

endpackage

>>> hw/rtl/npt_stack.sv
// Stack storage for heights and item numbers: one write and one read port,
// read data registered. Depends on npt_pkg.
module npt_stack #(
  parameter int unsigned MAX_TOWERS = npt_pkg::MAX_TOWERS_DEF,
  localparam int unsigned IDX_W     = (MAX_TOWERS > 1) ? $clog2(MAX_TOWERS) : 1,
  localparam int unsigned CNT_W     = $clog2(MAX_TOWERS + 1)
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [IDX_W-1:0]              waddr_i,
  input  logic [npt_pkg::HEIGHT_W-1:0]  wheight_i,
  input  logic [CNT_W-1:0]              wnum_i,
  input  logic                          re_i,
  input  logic [IDX_W-1:0]              raddr_i,
  output logic [npt_pkg::HEIGHT_W-1:0]  rheight_o,
  output logic [CNT_W-1:0]              rnum_o
);
  import npt_pkg::*;

  logic [HEIGHT_W+CNT_W-1:0] mem_q [MAX_TOWERS];
  logic [HEIGHT_W+CNT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wheight_i, wnum_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rheight_o = rdata_q[HEIGHT_W+CNT_W-1:CNT_W];
  assign rnum_o    = rdata_q[CNT_W-1:0];

endmodule

>>> hw/rtl/nearest_previous_taller_finder_top.sv
// Top level of the nearest previous taller finder: sequencer, counters and
// result register around the stack. Depends on npt_pkg and npt_stack.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------------
//   in      | in_valid_i / in_stall_o | first_of_set_i, tower_height_i
//   out     | out_valid_o / out_stall_i | item_number_o, target_index_o,
//           |                        | overflow_o
//
// A request goes from idle through compare to push, P being the entries it
// pops: one compare a cycle against the registered stack read, the last one
// finding the target. If the stack is or becomes empty no target is found;
// an overflowing one goes straight to push. A stalled result holds the push
// state; the result register lets a new request enter while a result waits.
// Reset clears counters and flags; stack contents need no clearing.
module nearest_previous_taller_finder_top #(
  parameter int unsigned MAX_TOWERS = npt_pkg::MAX_TOWERS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          first_of_set_i,
  input  logic [npt_pkg::HEIGHT_W-1:0]  tower_height_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [npt_pkg::NUM_W-1:0]     item_number_o,
  output logic [npt_pkg::NUM_W-1:0]     target_index_o,
  output logic                          overflow_o
);
  import npt_pkg::*;

  localparam int unsigned IDX_W = (MAX_TOWERS > 1) ? $clog2(MAX_TOWERS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TOWERS + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_TOWERS);

  npt_state_e          state_q, state_d;
  logic [CNT_W-1:0]    depth_q, depth_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                ovf_q, ovf_d;
  logic [HEIGHT_W-1:0] height_q, height_d;
  logic [CNT_W-1:0]    number_q, number_d;
  logic [CNT_W-1:0]    target_q, target_d;
  logic                res_ovf_q, res_ovf_d;
  logic                out_valid_q, out_valid_d;
  logic [NUM_W-1:0]    out_num_q, out_num_d;
  logic [NUM_W-1:0]    out_tgt_q, out_tgt_d;
  logic                out_ovf_q, out_ovf_d;

  logic                we;
  logic                re;
  logic [IDX_W-1:0]    raddr;
  logic [HEIGHT_W-1:0] rd_height;
  logic [CNT_W-1:0]    rd_num;

  logic [CNT_W-1:0]    eff_depth, eff_count, depth_m1, depth_m2;
  logic                eff_ovf, out_free;

  npt_stack #(
    .MAX_TOWERS(MAX_TOWERS)
  ) u_stack (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (depth_q[IDX_W-1:0]),
    .wheight_i (height_q),
    .wnum_i    (number_q),
    .re_i      (re),
    .raddr_i   (raddr),
    .rheight_o (rd_height),
    .rnum_o    (rd_num)
  );

  assign eff_depth = first_of_set_i ? '0 : depth_q;
  assign eff_count = first_of_set_i ? '0 : count_q;
  assign eff_ovf   = first_of_set_i ? 1'b0 : ovf_q;
  assign depth_m1  = eff_depth - 1'b1;
  assign depth_m2  = depth_q - CNT_W'(2);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    height_d    = height_q;
    number_d    = number_q;
    target_d    = target_q;
    res_ovf_d   = res_ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_num_d   = out_num_q;
    out_tgt_d   = out_tgt_q;
    out_ovf_d   = out_ovf_q;
    we          = 1'b0;
    re          = 1'b0;
    raddr       = depth_m1[IDX_W-1:0];
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          depth_d  = eff_depth;
          count_d  = eff_count;
          height_d = tower_height_i;
          target_d = '0;
          state_d  = ST_PUSH;
          if (eff_ovf || eff_count >= CAP) begin
            ovf_d     = 1'b1;
            res_ovf_d = 1'b1;
            number_d  = '0;
          end else begin
            ovf_d     = 1'b0;
            res_ovf_d = 1'b0;
            count_d   = eff_count + 1'b1;
            number_d  = eff_count + 1'b1;
            if (eff_depth != '0) begin
              re      = 1'b1;
              state_d = ST_CMP;
            end
          end
        end
      end
      ST_CMP: begin
        if (rd_height < height_q) begin
          depth_d = depth_q - 1'b1;
          if (depth_q == CNT_W'(1)) begin
            state_d = ST_PUSH;
          end else begin
            re    = 1'b1;
            raddr = depth_m2[IDX_W-1:0];
          end
        end else begin
          target_d = rd_num;
          state_d  = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          if (!res_ovf_q && depth_q < CAP) begin
            we      = 1'b1;
            depth_d = depth_q + 1'b1;
          end
          out_valid_d = 1'b1;
          out_num_d   = NUM_W'(number_q);
          out_tgt_d   = NUM_W'(target_q);
          out_ovf_d   = res_ovf_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      depth_q     <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    height_q  <= height_d;
    number_q  <= number_d;
    target_q  <= target_d;
    res_ovf_q <= res_ovf_d;
    out_num_q <= out_num_d;
    out_tgt_q <= out_tgt_d;
    out_ovf_q <= out_ovf_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign item_number_o  = out_num_q;
  assign target_index_o = out_tgt_q;
  assign overflow_o     = out_ovf_q;

endmodule

>>> tb/sv/nearest_previous_taller_finder_top_test.sv
// Self-checking testbench for nearest_previous_taller_finder_top: checks every result
// against a monotonic-stack predictor under random idling and stalling.
// Depends on npt_pkg and the RTL of the finder; reads no files.
`timescale 1ns / 100ps

module nearest_previous_taller_finder_top_test;
  import npt_pkg::*;

  localparam int unsigned MAX_TOWERS = MAX_TOWERS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TARGET_REQUESTS = 1900;

  typedef struct packed {
    logic                first;
    logic [HEIGHT_W-1:0] height;
  } tower_req_t;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic [NUM_W-1:0] target;
    logic             ovf;
  } tower_answer_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                first_of_set = 1'b0;
  logic [HEIGHT_W-1:0] tower_height = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [NUM_W-1:0]    item_number;
  logic [NUM_W-1:0]    target_index;
  logic                overflow;

  tower_req_t    towers_pending[$];
  tower_answer_t answers_due[$];
  int unsigned   total_requests;
  int unsigned   requests_sent = 0;
  int unsigned   bad_results = 0;
  int unsigned   cycles = 0;
  int unsigned   send_idle_pct;
  int unsigned   stall_pct;

  // predictor state
  logic [HEIGHT_W-1:0] taller_heights[MAX_TOWERS];
  int unsigned         taller_numbers[MAX_TOWERS];
  int unsigned         taller_depth = 0;
  int unsigned         towers_counted = 0;
  logic                seq_overflowed = 1'b0;

  nearest_previous_taller_finder_top #(
    .MAX_TOWERS(MAX_TOWERS)
  ) u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .first_of_set_i(first_of_set),
    .tower_height_i(tower_height),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .item_number_o (item_number),
    .target_index_o(target_index),
    .overflow_o    (overflow)
  );

  always #10 clk = ~clk;

  function automatic tower_answer_t find_taller(input logic first,
                                                input logic [HEIGHT_W-1:0] h);
    tower_answer_t a;
    a = '0;
    if (first) begin
      taller_depth = 0;
      towers_counted = 0;
      seq_overflowed = 1'b0;
    end
    if (seq_overflowed || towers_counted >= MAX_TOWERS) begin
      seq_overflowed = 1'b1;
      a.ovf = 1'b1;
      return a;
    end
    towers_counted++;
    a.number = towers_counted[NUM_W-1:0];
    while (taller_depth > 0 && taller_heights[taller_depth-1] < h)
      taller_depth--;
    if (taller_depth > 0)
      a.target = taller_numbers[taller_depth-1][NUM_W-1:0];
    if (taller_depth < MAX_TOWERS) begin
      taller_heights[taller_depth] = h;
      taller_numbers[taller_depth] = towers_counted;
      taller_depth++;
    end
    return a;
  endfunction

  task automatic add_tower(input logic first, input logic [HEIGHT_W-1:0] h);
    tower_req_t r;
    r.first = first;
    r.height = h;
    towers_pending.insert(towers_pending.size(), r);
  endtask

  // idling phases by progress through the stream
  always_comb begin
    if (requests_sent < total_requests / 3) begin
      send_idle_pct = 14;
      stall_pct = 48;
    end else if (requests_sent < 2 * total_requests / 3) begin
      send_idle_pct = 48;
      stall_pct = 14;
    end else begin
      send_idle_pct = 0;
      stall_pct = 0;
    end
  end

  always @(posedge clk or negedge rst_n) begin : drive
    tower_req_t    nxt;
    tower_answer_t due;
    logic          took;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        due = find_taller(first_of_set, tower_height);
        answers_due.insert(answers_due.size(), due);
        requests_sent <= requests_sent + 1;
      end
      if (!in_valid || took) begin
        if (towers_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = towers_pending.pop_front();
          in_valid <= 1'b1;
          first_of_set <= nxt.first;
          tower_height <= nxt.height;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin : check
    tower_answer_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          $error("unexpected result: item_number %0d target_index %0d overflow %0b",
                 item_number, target_index, overflow);
          bad_results++;
        end else begin
          want = answers_due.pop_front();
          if (item_number !== want.number) begin
            $error("item_number: expected %0d, got %0d", want.number, item_number);
            bad_results++;
          end
          if (target_index !== want.target) begin
            $error("target_index: expected %0d, got %0d", want.target, target_index);
            bad_results++;
          end
          if (overflow !== want.ovf) begin
            $error("overflow: expected %0b, got %0b", want.ovf, overflow);
            bad_results++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("nearest_previous_taller_finder_top: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    logic [HEIGHT_W-1:0] h;
    int unsigned         len;
    int unsigned         mode;
    int unsigned         step;

    // directed: no start flag after reset, equal heights, pops, extremes, restarts
    add_tower(1'b0, 32'd5);
    add_tower(1'b0, 32'd5);
    add_tower(1'b0, 32'd3);
    add_tower(1'b0, 32'd0);
    add_tower(1'b0, 32'd4);
    add_tower(1'b0, 32'hFFFF_FFFF);
    add_tower(1'b0, 32'hFFFF_FFFF);
    add_tower(1'b0, 32'd0);
    add_tower(1'b1, 32'd0);
    add_tower(1'b0, 32'd0);
    add_tower(1'b1, 32'hFFFF_FFFF);
    add_tower(1'b0, 32'hFFFF_FFFE);
    add_tower(1'b0, 32'hAAAA_AAAA);
    add_tower(1'b0, 32'h5555_5555);
    add_tower(1'b0, 32'h8000_0000);
    add_tower(1'b1, 32'd1);
    add_tower(1'b0, 32'd2);
    add_tower(1'b0, 32'd2);
    add_tower(1'b0, 32'd1);

    // full stack, then requests past capacity until the next start flag
    h = 32'hFFFF_FFFF;
    add_tower(1'b1, h);
    for (int i = 1; i < MAX_TOWERS; i++) begin
      step = $urandom_range(0, 3);
      h = h - step;
      add_tower(1'b0, h);
    end
    add_tower(1'b0, 32'hFFFF_FFFF);
    add_tower(1'b0, 32'd0);
    add_tower(1'b0, $urandom);

    // deep stack emptied by one tall request
    h = $urandom_range(32'h1000, 32'hFFFF_0000);
    add_tower(1'b1, h);
    for (int i = 0; i < 300; i++) begin
      step = $urandom_range(0, 7);
      if (h >= step) h = h - step;
      add_tower(1'b0, h);
    end
    add_tower(1'b0, 32'hFFFF_FFFF);

    // short sequences of mixed shape
    while (towers_pending.size() < TARGET_REQUESTS) begin
      len = $urandom_range(1, 40);
      mode = $urandom_range(0, 3);
      h = $urandom;
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: begin
            h = $urandom_range(0, 7);
          end
          1: begin
            h = $urandom;
          end
          2: begin
            step = $urandom_range(0, 4);
            if ($urandom_range(0, 9) == 0) h = $urandom;
            else if (h >= step) h = h - step;
          end
          default: begin
            case ($urandom_range(0, 4))
              0: h = 32'd0;
              1: h = 32'd1;
              2: h = 32'hFFFF_FFFF;
              3: h = 32'hFFFF_FFFE;
              default: h = $urandom;
            endcase
          end
        endcase
        add_tower(i == 0 && $urandom_range(0, 7) != 0, h);
      end
    end
    total_requests = towers_pending.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (towers_pending.size() != 0 || in_valid || answers_due.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);

    if (bad_results == 0) begin
      $display("nearest_previous_taller_finder_top: match");
    end else begin
      $display("nearest_previous_taller_finder_top: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/npt_pkg.sv
hw/rtl/npt_stack.sv
hw/rtl/nearest_previous_taller_finder_top.sv
tb/sv/nearest_previous_taller_finder_top_test.sv
